// ===== hdl/frwl_pkg.sv =====
// Package for the reader-writer lock manager: field widths, operation and
// status codes, request/response/command structs and back-end states.
// Used by every module under hdl; depends on nothing.
package frwl_pkg;

   localparam int ID_BITS       = 8;
   localparam int OP_BITS       = 3;
   localparam int STATUS_BITS   = 4;
   localparam int COUNT_BITS    = 8;
   localparam int READER_MAX    = 255;
   localparam int MAX_RESULTS   = 32;
   localparam int RES_CNT_BITS  = $clog2(MAX_RESULTS + 1);
   // Command queue depth must be a power of two.
   localparam int CMDQ_DEPTH    = 2;
   localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [OP_BITS-1:0] {
      OP_READ_LOCK    = 3'd0,
      OP_TRY_READ     = 3'd1,
      OP_READ_UNLOCK  = 3'd2,
      OP_WRITE_LOCK   = 3'd3,
      OP_TRY_WRITE    = 3'd4,
      OP_WRITE_UNLOCK = 3'd5
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_GRANTED         = 4'd0,
      ST_QUEUED          = 4'd1,
      ST_REFUSED         = 4'd2,
      ST_WOKEN           = 4'd3,
      ST_RELEASED        = 4'd4,
      ST_NOT_HELD        = 4'd5,
      ST_QUEUE_FULL      = 4'd6,
      ST_HEAD_NOT_WRITER = 4'd7,
      ST_READERS_FULL    = 4'd8
   } status_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_WAKE = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [OP_BITS-1:0] operation;
      logic [ID_BITS-1:0] requester;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0]     target;
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  reader_count;
      logic                   writer_holds;
      logic                   last;
   } rsp_type;

   // Classified request as handed from front to back.
   typedef struct packed {
      logic               is_write;
      logic               is_try;
      logic               is_unlock;
      logic [ID_BITS-1:0] who;
   } cmd_type;

endpackage

// ===== hdl/frwl_front.sv =====
// Front stage: accepts requests, drops undefined operation codes and
// classifies the rest into commands. Depends on frwl_pkg.
module frwl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  frwl_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_stall,
   output frwl_pkg::cmd_type cmd_data
);

   logic              valid_ff, valid_in;
   frwl_pkg::cmd_type cmd_ff, cmd_in;
   logic              load;
   logic              op_ok;

   assign req_stall = valid_ff && cmd_stall;
   assign load      = req_valid && !req_stall;
   assign op_ok     = req_data.operation <= frwl_pkg::OP_WRITE_UNLOCK;

   always_comb begin
      cmd_in           = cmd_ff;
      cmd_in.is_write  = (req_data.operation == frwl_pkg::OP_WRITE_LOCK) ||
                         (req_data.operation == frwl_pkg::OP_TRY_WRITE) ||
                         (req_data.operation == frwl_pkg::OP_WRITE_UNLOCK);
      cmd_in.is_try    = (req_data.operation == frwl_pkg::OP_TRY_READ) ||
                         (req_data.operation == frwl_pkg::OP_TRY_WRITE);
      cmd_in.is_unlock = (req_data.operation == frwl_pkg::OP_READ_UNLOCK) ||
                         (req_data.operation == frwl_pkg::OP_WRITE_UNLOCK);
      cmd_in.who       = req_data.requester;
      if (load) begin
         valid_in = op_ok;
      end else if (!cmd_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

endmodule

// ===== hdl/frwl_cmdq.sv =====
// Short command queue between front and back stages.
// Depends on frwl_pkg for the command type and depth.
module frwl_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  frwl_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output frwl_pkg::cmd_type pop_data
);

   frwl_pkg::cmd_type                        entry_ff [frwl_pkg::CMDQ_DEPTH];
   logic [frwl_pkg::CMDQ_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [frwl_pkg::CMDQ_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [frwl_pkg::CMDQ_CNT_BITS-1:0]       count_ff, count_in;
   logic                                     do_push, do_pop;

   assign full     = count_ff == frwl_pkg::CMDQ_CNT_BITS'(frwl_pkg::CMDQ_DEPTH);
   assign valid    = count_ff != '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/frwl_back.sv =====
// Back stage: lock state, waiter memory and response register; carries out
// one command at a time and walks queued readers on a write unlock.
// Depends on frwl_pkg.
module frwl_back #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  frwl_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output frwl_pkg::rsp_type rsp_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W  = frwl_pkg::ID_BITS;
   localparam int RC_W  = frwl_pkg::COUNT_BITS;
   localparam int RN_W  = frwl_pkg::RES_CNT_BITS;

   frwl_pkg::back_state_type state_ff, state_in;
   logic [RC_W-1:0]  readers_ff, readers_in;
   logic             writer_ff, writer_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [RN_W-1:0]  woken_ff, woken_in;
   logic [ID_W-1:0]  pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   frwl_pkg::rsp_type rsp_ff, rsp_in;
   logic [ID_W:0]    head_data_ff;
   logic [ID_W:0]    mem [QUEUE_DEPTH];

   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [ID_W:0]    wr_data;
   logic [CNT_W:0]   tail_sum;
   logic [PTR_W-1:0] tail;
   logic [PTR_W-1:0] head_next;
   logic             head_tag;
   logic [ID_W-1:0]  head_id;
   logic             q_full, q_empty;
   logic             out_free;
   logic             more;
   logic             em, em_last, em_wr;
   logic [ID_W-1:0]  em_tgt;
   logic [RC_W-1:0]  em_rc;
   frwl_pkg::status_type em_st;

   assign head_tag  = head_data_ff[ID_W];
   assign head_id   = head_data_ff[ID_W-1:0];
   assign q_full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign q_empty   = count_ff == '0;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_next = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
   assign tail      = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

   // Keep walking readers while one is at the head and bounds allow.
   assign more = !q_empty && (woken_ff < RN_W'(frwl_pkg::MAX_RESULTS)) &&
                 (readers_ff != RC_W'(frwl_pkg::READER_MAX)) && !head_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frwl_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      readers_in   = readers_ff;
      writer_in    = writer_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      woken_in     = woken_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = tail;
      wr_data      = {cmd_data.is_write, cmd_data.who};
      em           = 1'b0;
      em_last      = 1'b1;
      em_tgt       = cmd_data.who;
      em_st        = frwl_pkg::ST_GRANTED;
      em_rc        = readers_ff;
      em_wr        = writer_ff;
      case (state_ff)
         frwl_pkg::BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               em      = 1'b1;
               if (!cmd_data.is_write && !cmd_data.is_unlock) begin
                  if (!writer_ff && q_empty) begin
                     if (readers_ff == RC_W'(frwl_pkg::READER_MAX)) begin
                        em_st = frwl_pkg::ST_READERS_FULL;
                     end else begin
                        readers_in = readers_ff + 1'b1;
                        em_st      = frwl_pkg::ST_GRANTED;
                     end
                  end else if (cmd_data.is_try) begin
                     em_st = frwl_pkg::ST_REFUSED;
                  end else if (q_full) begin
                     em_st = frwl_pkg::ST_QUEUE_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     em_st    = frwl_pkg::ST_QUEUED;
                  end
               end else if (!cmd_data.is_write) begin
                  // read unlock
                  if (readers_ff == '0) begin
                     em_st = frwl_pkg::ST_NOT_HELD;
                  end else begin
                     readers_in = readers_ff - 1'b1;
                     if (readers_ff != RC_W'(1) || q_empty) begin
                        em_st = frwl_pkg::ST_RELEASED;
                     end else if (!head_tag) begin
                        em_st = frwl_pkg::ST_HEAD_NOT_WRITER;
                     end else begin
                        head_in   = head_next;
                        count_in  = count_ff - 1'b1;
                        writer_in = 1'b1;
                        em_tgt    = head_id;
                        em_st     = frwl_pkg::ST_WOKEN;
                     end
                  end
               end else if (!cmd_data.is_unlock) begin
                  if (readers_ff == '0 && !writer_ff) begin
                     writer_in = 1'b1;
                     em_st     = frwl_pkg::ST_GRANTED;
                  end else if (cmd_data.is_try) begin
                     em_st = frwl_pkg::ST_REFUSED;
                  end else if (q_full) begin
                     em_st = frwl_pkg::ST_QUEUE_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     em_st    = frwl_pkg::ST_QUEUED;
                  end
               end else begin
                  // write unlock
                  if (!writer_ff) begin
                     em_st = frwl_pkg::ST_NOT_HELD;
                  end else if (q_empty) begin
                     writer_in = 1'b0;
                     em_st     = frwl_pkg::ST_RELEASED;
                  end else if (head_tag) begin
                     head_in  = head_next;
                     count_in = count_ff - 1'b1;
                     em_tgt   = head_id;
                     em_st    = frwl_pkg::ST_WOKEN;
                  end else begin
                     // Take the first reader now; its result leaves from the
                     // walk, once the next head is known.
                     em         = 1'b0;
                     writer_in  = 1'b0;
                     head_in    = head_next;
                     count_in   = count_ff - 1'b1;
                     readers_in = readers_ff + 1'b1;
                     pend_in    = head_id;
                     woken_in   = RN_W'(1);
                     state_in   = frwl_pkg::BK_WAKE;
                  end
               end
               em_rc = readers_in;
               em_wr = writer_in;
            end
         end
         frwl_pkg::BK_WAKE: begin
            if (out_free) begin
               em      = 1'b1;
               em_tgt  = pend_ff;
               em_st   = frwl_pkg::ST_WOKEN;
               em_rc   = readers_ff;
               em_wr   = writer_ff;
               em_last = !more;
               if (more) begin
                  head_in    = head_next;
                  count_in   = count_ff - 1'b1;
                  readers_in = readers_ff + 1'b1;
                  pend_in    = head_id;
                  woken_in   = woken_ff + 1'b1;
               end else begin
                  state_in = frwl_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = frwl_pkg::BK_IDLE;
         end
      endcase
      if (em) begin
         rsp_valid_in        = 1'b1;
         rsp_in.target       = em_tgt;
         rsp_in.status       = em_st;
         rsp_in.reader_count = em_rc;
         rsp_in.writer_holds = em_wr;
         rsp_in.last         = em_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         readers_ff   <= '0;
         writer_ff    <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         woken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         readers_ff   <= readers_in;
         writer_ff    <= writer_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         woken_ff     <= woken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Waiter memory; the registered read follows the next head and takes a
   // write to that same slot straight through.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == head_in)) begin
         head_data_ff <= wr_data;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/fifo_reader_writer_lock_core.sv =====
// Top level of the reader-writer lock manager for one lock.
// Depends on frwl_pkg, frwl_front, frwl_cmdq and frwl_back.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   frwl_pkg::req_type
//   rsp_      out        rsp_valid/rsp_stall   frwl_pkg::rsp_type
//
// A request passes from the front register into a two-entry command queue,
// where it waits until the back stage takes it; the back stage puts its
// result in the response register, which drives rsp_valid. The back stage
// takes one command a cycle while rsp_ is not stalled and no walk is under
// way, so one-result requests run at one per cycle; a write unlock that
// wakes readers holds the back stage while it takes the first reader, then
// gives one result a cycle for each while rsp_ is not stalled.
// Reset clears lock state and queue counts; the waiter memory is not cleared.
// A stall on rsp_ holds the response register and the back stage, the
// command queue fills, and req_stall rises.
module fifo_reader_writer_lock_core #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  frwl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output frwl_pkg::rsp_type rsp_data
);

   // Front-to-queue and queue-to-back command transfers.
   logic              front_valid;
   logic              q_full;
   frwl_pkg::cmd_type front_cmd;
   logic              q_valid;
   logic              q_pop;
   frwl_pkg::cmd_type q_cmd;

   // Accept and classify; drop undefined codes here.
   frwl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_stall (q_full),
      .cmd_data  (front_cmd)
   );

   // Decouple the two sides so each may stall on its own.
   frwl_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_cmd)
   );

   // Execute against the lock state and drive results.
   frwl_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_data  (q_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
